### hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hdl/dks_pkg.sv
// Shared types and constants of the keyword search block.
`default_nettype none
package dks_pkg;
  localparam int unsigned DefMaxWords = 64;
  localparam int unsigned DefMaxLen   = 16;
  localparam int unsigned DefLetters  = 26;
  localparam logic [7:0]  CharA       = 8'h61;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Word passed from the front to the back through the queue.
  typedef struct packed {
    mode_e      mode;
    logic [7:0] character;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_READ,
    ST_CMP,
    ST_DONE
  } srch_state_e;
endpackage
`default_nettype wire

### hdl/dks_front.sv
// Front part: accepts command words and queues them for the back part.
`default_nettype none
module dks_front import dks_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] character_i,
  input  wire logic       last_i,
  output logic            busy_o,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o,
  input  wire logic       cmd_pop_i
);
  // Two-entry queue.
  cmd_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= '{mode: mode_e'(mode_i), character: character_i, last: last_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end
endmodule
`default_nettype wire

### hdl/dks_back.sv
// Back part: table clearing and loading, query buffering and block binary search.
`default_nettype none
module dks_back import dks_pkg::*; #(
  parameter int unsigned MaxWords = DefMaxWords,
  parameter int unsigned MaxLen   = DefMaxLen,
  parameter int unsigned Letters  = DefLetters
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      done_o,
  output logic      is_keyword_o,
  output logic      query_too_long_o
);
  localparam int unsigned RowW = $clog2(MaxWords);
  localparam int unsigned CntW = $clog2(MaxWords + 1);
  localparam int unsigned PosW = $clog2(MaxLen);
  localparam int unsigned LenW = $clog2(MaxLen + 1);
  localparam int unsigned LetW = (Letters > 1) ? $clog2(Letters) : 1;
  localparam int unsigned WordW = 8 * MaxLen;

  logic [WordW-1:0] mem_q [MaxWords];
  logic [LenW-1:0]  len_mem_q [MaxWords];
  logic [WordW-1:0] rd_word_q;
  logic [LenW-1:0]  rd_len_q;

  logic [Letters-1:0] ix_valid_q;
  logic [RowW-1:0]    ix_begin_q [Letters];
  logic [RowW-1:0]    ix_end_q [Letters];

  logic [CntW-1:0]  count_q;
  logic [LenW-1:0]  lpos_q;
  logic [WordW-1:0] lword_q;
  logic [WordW-1:0] qbuf_q;
  logic [LenW-1:0]  qlen_q;
  logic             qovf_q;

  srch_state_e state_q, state_d;
  logic signed [RowW+1:0] lo_q, hi_q, mid_q;
  logic signed [RowW+1:0] mid_nx;
  logic found_q, ovf_res_q;
  logic done_q;

  assign done_o           = done_q;
  assign is_keyword_o     = found_q;
  assign query_too_long_o = ovf_res_q;

  logic is_query_end;
  assign is_query_end = cmd_i.mode == MODE_QUERY && cmd_i.last;
  assign cmd_pop_o = cmd_valid_i && state_q == ST_IDLE;

  // Probe row; the memory is read at this address so the row is ready in ST_CMP.
  assign mid_nx = lo_q + ((hi_q - lo_q) >>> 1);

  // Load path.
  logic             ld_ok, ld_wr;
  logic [WordW-1:0] lword_new;
  logic [LenW-1:0]  lpos_new;
  logic [7:0]       first_ch;
  logic [7:0]       first_off;
  assign ld_ok = cmd_pop_o && cmd_i.mode == MODE_LOAD && count_q < CntW'(MaxWords);
  assign ld_wr = lpos_q < LenW'(MaxLen);
  always_comb begin
    lword_new = lword_q;
    lpos_new  = lpos_q;
    if (ld_wr) begin
      lword_new[8*lpos_q[PosW-1:0] +: 8] = cmd_i.character;
      lpos_new = lpos_q + 1'b1;
    end
  end
  assign first_ch  = lword_new[7:0];
  assign first_off = first_ch - CharA;

  // Query first letter.
  logic [7:0] q_off;
  logic       q_in;
  assign q_off = qbuf_q[7:0] - CharA;
  assign q_in  = qlen_q != '0 && qbuf_q[7:0] >= CharA && q_off < 8'(Letters);

  // Compare of registered row with the query: eq, lt (row < query).
  logic cmp_eq, cmp_lt, decided;
  always_comb begin
    cmp_eq = 1'b0;
    cmp_lt = 1'b0;
    decided = 1'b0;
    for (int k = 0; k < MaxLen; k++) begin
      if (!decided && LenW'(k) < rd_len_q && LenW'(k) < qlen_q &&
          rd_word_q[8*k +: 8] != qbuf_q[8*k +: 8]) begin
        decided = 1'b1;
        cmp_lt  = rd_word_q[8*k +: 8] < qbuf_q[8*k +: 8];
      end
    end
    if (!decided) begin
      cmp_eq = rd_len_q == qlen_q;
      cmp_lt = rd_len_q < qlen_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_ok && cmd_i.last) begin
      mem_q[count_q[RowW-1:0]]     <= lword_new;
      len_mem_q[count_q[RowW-1:0]] <= lpos_new;
    end
    rd_word_q <= mem_q[mid_nx[RowW-1:0]];
    rd_len_q  <= len_mem_q[mid_nx[RowW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (cmd_pop_o && is_query_end) state_d = ST_LOOKUP;
      ST_LOOKUP: begin
        if (qovf_q || !q_in || !ix_valid_q[q_off[LetW-1:0]]) state_d = ST_DONE;
        else state_d = ST_READ;
      end
      ST_READ:   state_d = (lo_q <= hi_q) ? ST_CMP : ST_DONE;
      ST_CMP:    state_d = ST_READ;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_valid_q <= '0;
      for (int k = 0; k < Letters; k++) begin
        ix_begin_q[k] <= '0;
        ix_end_q[k]   <= '0;
      end
      count_q    <= '0;
      lpos_q     <= '0;
      lword_q    <= '0;
      qlen_q     <= '0;
      qovf_q     <= 1'b0;
      qbuf_q     <= '0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      ovf_res_q  <= 1'b0;
      lo_q       <= '0;
      hi_q       <= '0;
      mid_q      <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_pop_o && cmd_i.mode == MODE_CLEAR) begin
        ix_valid_q <= '0;
        count_q    <= '0;
        lpos_q     <= '0;
      end
      if (ld_ok) begin
        if (cmd_i.last) begin
          lpos_q  <= '0;
          count_q <= count_q + 1'b1;
          if (first_ch >= CharA && first_off < 8'(Letters)) begin
            if (!ix_valid_q[first_off[LetW-1:0]]) begin
              ix_begin_q[first_off[LetW-1:0]] <= count_q[RowW-1:0];
            end
            ix_valid_q[first_off[LetW-1:0]] <= 1'b1;
            ix_end_q[first_off[LetW-1:0]]   <= count_q[RowW-1:0];
          end
        end else begin
          lpos_q <= lpos_new;
        end
        lword_q <= lword_new;
      end
      if (cmd_pop_o && cmd_i.mode == MODE_QUERY) begin
        if (qlen_q < LenW'(MaxLen)) begin
          qbuf_q[8*qlen_q[PosW-1:0] +: 8] <= cmd_i.character;
          qlen_q <= qlen_q + 1'b1;
        end else begin
          qovf_q <= 1'b1;
        end
      end
      unique case (state_q)
        ST_LOOKUP: begin
          found_q   <= 1'b0;
          ovf_res_q <= qovf_q;
          lo_q <= (RowW+2)'(ix_begin_q[q_off[LetW-1:0]]);
          if ({1'b0, ix_end_q[q_off[LetW-1:0]]} >= (RowW+1)'(count_q)) begin
            hi_q <= (RowW+2)'(count_q) - 1'b1;
          end else begin
            hi_q <= (RowW+2)'(ix_end_q[q_off[LetW-1:0]]);
          end
        end
        ST_READ: mid_q <= mid_nx;
        ST_CMP: begin
          if (cmp_eq) begin
            found_q <= 1'b1;
            hi_q    <= lo_q - 1'b1;
          end else if (cmp_lt) begin
            lo_q <= mid_q + 1'b1;
          end else begin
            hi_q <= mid_q - 1'b1;
          end
        end
        ST_DONE: begin
          done_q <= 1'b1;
          qbuf_q <= '0;
          qlen_q <= '0;
          qovf_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/direct_index_keyword_search.sv
// Top level of the keyword search block.
//  channel | direction | handshake        | fields
//  command | in        | start_i / busy_o | mode_i, character_i, last_i
//  result  | out       | done_o strobe    | is_keyword_o, query_too_long_o
// The back part takes command words while idle; a final query word starts a search:
// ST_LOOKUP, then ST_READ and ST_CMP for each of S binary search probes (one memory
// read, one compare) over the query's letter block (S <= log2(MAX_WORDS)+1), then a
// last ST_READ and ST_DONE; a too-long query or one with no block skips to ST_DONE.
// A two-word queue lets the front accept words while the back searches.
// Reset empties the index and counters at once; there is no clearing pass.
// The receiver cannot stall; results are strobed for one cycle.
`default_nettype none
module direct_index_keyword_search import dks_pkg::*; #(
  parameter int unsigned MaxWords = DefMaxWords,
  parameter int unsigned MaxLen   = DefMaxLen,
  parameter int unsigned Letters  = DefLetters
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] character_i,
  input  wire logic       last_i,
  output logic            done_o,
  output logic            is_keyword_o,
  output logic            query_too_long_o
);
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  dks_front u_front (
    .clk_i, .rst_ni, .start_i, .mode_i, .character_i, .last_i, .busy_o,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  dks_back #(.MaxWords(MaxWords), .MaxLen(MaxLen), .Letters(Letters)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .done_o, .is_keyword_o, .query_too_long_o
  );
endmodule
`default_nettype wire

### hdl/dks_checker.sv
// Port-level checker for the keyword search block and its bind.
`default_nettype none
`include "assert_macros.svh"
module dks_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic done_o,
  input wire logic is_keyword_o,
  input wire logic query_too_long_o
);
  `CHK_IMPLY(a_long_not_found, clk_i, rst_ni, done_o && query_too_long_o, !is_keyword_o, "long query reported found")
  `CHK_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "result strobe longer than one cycle")
  `CHK_NEXT(a_busy_needs_work, clk_i, rst_ni, !busy_o && !start_i, !busy_o, "busy rose without input")
endmodule
bind direct_index_keyword_search dks_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .is_keyword_o, .query_too_long_o
);
`default_nettype wire

### tb/tb_direct_index_keyword_search.sv
// Testbench for the keyword search block: directed table, then random words.
`timescale 1ns / 100ps
`default_nettype none
module tb_direct_index_keyword_search;
  import dks_pkg::*;

  localparam int unsigned NumWords = DefMaxWords;
  localparam int unsigned WordLen  = DefMaxLen;
  localparam int unsigned NumLet   = DefLetters;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic is_kw;
    logic too_long;
  } verdict_t;

  typedef struct {
    mode_e      mode;
    logic [7:0] ch;
    logic       last;
    logic       typed;
    verdict_t   want;
  } row_t;

  logic clk, rst_n;
  logic start, busy, done, is_kw, too_long;
  logic [1:0] mode;
  logic [7:0] ch;
  logic last;

  direct_index_keyword_search u_top (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .mode_i(mode), .character_i(ch), .last_i(last),
    .done_o(done), .is_keyword_o(is_kw), .query_too_long_o(too_long)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Shadow copy of the keyword table.
  logic [7:0] kw_bytes [NumWords][WordLen];
  int unsigned kw_len [NumWords];
  logic blk_valid [NumLet];
  int blk_first [NumLet];
  int blk_last [NumLet];
  int unsigned kw_count, load_pos;
  logic [7:0] q_bytes [WordLen];
  int unsigned q_len;
  logic q_over;

  verdict_t pending_verdicts[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned words_sent;

  function automatic int row_order(int unsigned r);
    int unsigned n;
    n = kw_len[r] < q_len ? kw_len[r] : q_len;
    for (int unsigned k = 0; k < n; k++)
      if (kw_bytes[r][k] != q_bytes[k]) return kw_bytes[r][k] < q_bytes[k] ? -1 : 1;
    if (kw_len[r] == q_len) return 0;
    return kw_len[r] < q_len ? -1 : 1;
  endfunction

  function automatic logic lookup_query();
    int lo, hi, mid, c;
    int unsigned li;
    if (q_len == 0 || q_bytes[0] < CharA) return 1'b0;
    li = q_bytes[0] - CharA;
    if (li >= NumLet || !blk_valid[li]) return 1'b0;
    lo = blk_first[li];
    hi = blk_last[li];
    if (hi >= int'(kw_count)) hi = int'(kw_count) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      c = row_order(mid);
      if (c == 0) return 1'b1;
      if (c < 0) lo = mid + 1;
      else hi = mid - 1;
    end
    return 1'b0;
  endfunction

  task automatic wipe_table();
    kw_count = 0;
    load_pos = 0;
    for (int k = 0; k < NumLet; k++) begin
      blk_valid[k] = 1'b0;
      blk_first[k] = 0;
      blk_last[k] = 0;
    end
  endtask

  // Advances the shadow state by one accepted word and queues any verdict.
  task automatic apply_word(logic [1:0] m, logic [7:0] c, logic l);
    verdict_t v;
    int unsigned li;
    case (m)
      MODE_CLEAR: wipe_table();
      MODE_LOAD: begin
        if (kw_count < NumWords) begin
          if (load_pos < WordLen) begin
            kw_bytes[kw_count][load_pos] = c;
            load_pos++;
          end
          if (l) begin
            kw_len[kw_count] = load_pos;
            if (kw_bytes[kw_count][0] >= CharA && kw_bytes[kw_count][0] - CharA < NumLet) begin
              li = kw_bytes[kw_count][0] - CharA;
              if (!blk_valid[li]) begin
                blk_valid[li] = 1'b1;
                blk_first[li] = kw_count;
              end
              blk_last[li] = kw_count;
            end
            kw_count++;
            load_pos = 0;
          end
        end
      end
      MODE_QUERY: begin
        if (q_len < WordLen) begin
          q_bytes[q_len] = c;
          q_len++;
        end else begin
          q_over = 1'b1;
        end
        if (l) begin
          v.too_long = q_over;
          v.is_kw = q_over ? 1'b0 : lookup_query();
          pending_verdicts.push_back(v);
          q_len = 0;
          q_over = 1'b0;
          for (int k = 0; k < WordLen; k++) q_bytes[k] = 8'h00;
        end
      end
      default: ;
    endcase
  endtask

  // Drives one word and waits for it to be accepted.
  task automatic send_word(logic [1:0] m, logic [7:0] c, logic l);
    mode <= m;
    ch <= c;
    last <= l;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_word(m, c, l);
    words_sent++;
  endtask

  task automatic pause_sender(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_text(logic [1:0] m, string s);
    for (int k = 0; k < s.len(); k++) send_word(m, s[k], k == s.len() - 1);
  endtask

  // Random word, mostly lowercase, sometimes any byte, sometimes long.
  task automatic send_rand_word(logic [1:0] m, logic [7:0] first);
    int unsigned n;
    logic [7:0] c;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(WordLen + 1, WordLen + 4)
                                      : $urandom_range(1, 4);
    for (int unsigned k = 0; k < n; k++) begin
      c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(97, 100));
      if (k == 0) c = first;
      send_word(m, c, k == n - 1);
      if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 4));
    end
  endtask

  // Result checker; also the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (done) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %b %b", is_kw, too_long);
        end else if (pending_verdicts[0] != {is_kw, too_long}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected kw=%b long=%b, got kw=%b long=%b",
                     pending_verdicts[0].is_kw, pending_verdicts[0].too_long, is_kw, too_long);
          void'(pending_verdicts.pop_front());
        end else begin
          void'(pending_verdicts.pop_front());
        end
      end
    end
  end

  row_t dir_rows[$];
  task automatic add_row(mode_e m, logic [7:0] c, logic l, logic t, verdict_t w);
    row_t r;
    r.mode = m; r.ch = c; r.last = l; r.typed = t; r.want = w;
    dir_rows.push_back(r);
  endtask

  initial begin
    logic [7:0] pick;
    int unsigned nrows;
    idle_cycles = 0;
    mismatches = 0;
    words_sent = 0;
    start = 1'b0;
    mode = MODE_NONE;
    ch = 8'h00;
    last = 1'b0;
    rst_n = 1'b0;
    wipe_table();
    q_len = 0;
    q_over = 1'b0;
    for (int k = 0; k < WordLen; k++) q_bytes[k] = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: empty table, extremes of the character, mode three.
    add_row(MODE_QUERY, 8'h61, 1'b1, 1'b1, '{1'b0, 1'b0});
    add_row(MODE_QUERY, 8'hff, 1'b1, 1'b1, '{1'b0, 1'b0});
    add_row(MODE_QUERY, 8'h00, 1'b1, 1'b1, '{1'b0, 1'b0});
    add_row(MODE_NONE, 8'h61, 1'b1, 1'b0, '{1'b0, 1'b0});
    add_row(MODE_LOAD, 8'h61, 1'b1, 1'b0, '{1'b0, 1'b0});
    add_row(MODE_LOAD, 8'h7a, 1'b1, 1'b0, '{1'b0, 1'b0});
    add_row(MODE_LOAD, 8'h7b, 1'b1, 1'b0, '{1'b0, 1'b0});
    add_row(MODE_QUERY, 8'h61, 1'b1, 1'b0, '{1'b0, 1'b0});
    add_row(MODE_QUERY, 8'h7a, 1'b1, 1'b0, '{1'b0, 1'b0});
    add_row(MODE_QUERY, 8'h7b, 1'b1, 1'b1, '{1'b0, 1'b0});
    add_row(MODE_QUERY, 8'h60, 1'b1, 1'b1, '{1'b0, 1'b0});
    add_row(MODE_QUERY, 8'h62, 1'b1, 1'b1, '{1'b0, 1'b0});
    add_row(MODE_CLEAR, 8'h00, 1'b0, 1'b0, '{1'b0, 1'b0});
    add_row(MODE_QUERY, 8'h61, 1'b1, 1'b1, '{1'b0, 1'b0});
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].mode, dir_rows[i].ch, dir_rows[i].last);
      if (dir_rows[i].mode == MODE_QUERY && dir_rows[i].last && dir_rows[i].typed &&
          pending_verdicts.size() > 0)
        pending_verdicts[$] = dir_rows[i].want;
    end

    // Sorted table with a long word, then hits, misses and an over-long query.
    send_text(MODE_LOAD, "ab");
    send_text(MODE_LOAD, "abc");
    send_text(MODE_LOAD, "abcdefghijklmnopqrs");
    send_text(MODE_LOAD, "b");
    send_text(MODE_QUERY, "abc");
    send_text(MODE_QUERY, "abcdefghijklmnop");
    send_text(MODE_QUERY, "abcdefghijklmnopq");
    send_text(MODE_QUERY, "b");
    send_text(MODE_QUERY, "ba");
    start <= 1'b0;
    while (pending_verdicts.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    // Random part: sorted tables of random words, queries from the same alphabet.
    while (words_sent < 1550) begin
      send_word(MODE_CLEAR, 8'($urandom), 1'($urandom));
      for (int unsigned letter = 0; letter < NumLet; letter++) begin
        if ($urandom_range(0, 3) == 0) begin
          nrows = $urandom_range(1, 3);
          for (int unsigned j = 1; j <= nrows; j++) begin
            send_text(MODE_LOAD, {string'(8'(CharA + letter)), string'(8'(96 + j))});
          end
        end
      end
      // Occasionally fill past capacity.
      if ($urandom_range(0, 6) == 0)
        repeat (NumWords + 2) begin
          send_word(MODE_LOAD, 8'($urandom), 1'b1);
        end
      repeat ($urandom_range(10, 30)) begin
        pick = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(97, 122));
        if ($urandom_range(0, 19) == 0) send_word(MODE_NONE, 8'($urandom), 1'($urandom));
        send_rand_word(MODE_QUERY, pick);
      end
      if ($urandom_range(0, 4) == 0) begin
        pause_sender(1);
        while (pending_verdicts.size() > 0) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end

    start <= 1'b0;
    while (pending_verdicts.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
